[design/sse_pkg.sv]
// Shared types and constants for the spectral step size estimator.
// Used by the top level, the ratio divider and the port checker; no dependencies.
package sse_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int DEF_MAX_LEN  = 1024;
    localparam int STEP_W       = 32;
    localparam int SUM_W        = 64;
    localparam int FRAC_BITS    = 16;
    localparam int CFG_IDX_W    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_STEP = 2'd0,
        CFG_MAX_STEP = 2'd1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ACT_COMPUTE = 2'd0,
        ACT_RECORD  = 2'd1,
        ACT_FORGET  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        SRC_SPECTRAL     = 2'd0,
        SRC_NO_HISTORY   = 2'd1,
        SRC_LEN_MISMATCH = 2'd2,
        SRC_CURVATURE    = 2'd3
    } t_source;

    typedef struct packed {
        logic [1:0]                     action;
        logic signed [SAMPLE_WIDTH-1:0] position_value;
        logic signed [SAMPLE_WIDTH-1:0] gradient_value;
        logic [STEP_W-1:0]              initial_step;
        logic                           last_element;
    } t_in_item;

    typedef struct packed {
        logic [STEP_W-1:0] step_size;
        logic [1:0]        step_source;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] num;
        logic [SUM_W-2:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [STEP_W-1:0] ratio;
    } t_div_rsp;

endpackage

[design/sse_div.sv]
// Bit-serial restoring divider producing ss/sy in Q16.16, saturated to all ones.
// Depends on sse_pkg for the request and response structs.
module sse_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sse_pkg::t_div_req i_req,
    output sse_pkg::t_div_rsp o_rsp
);
    import sse_pkg::*;

    localparam int NUM_W  = SUM_W + FRAC_BITS;
    localparam int DEN_W  = SUM_W - 1;
    localparam int ITER_W = $clog2(NUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [ITER_W-1:0] r_iter;
    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_quot;
    logic              r_ovf;

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;
    logic [DEN_W-1:0]  n_rem;

    always_comb begin
        trial = {r_rem, r_num[NUM_W-1]};
        ge    = trial >= {1'b0, r_den};
        diff  = trial - {1'b0, r_den};
        // The remainder always stays below the divisor, so it fits DEN_W bits.
        n_rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_iter <= ITER_W'(NUM_W);
            end else if (r_busy) begin
                r_iter <= r_iter - ITER_W'(1);
                if (r_iter == ITER_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num  <= {i_req.num, {FRAC_BITS{1'b0}}};
            r_den  <= i_req.den;
            r_rem  <= '0;
            r_quot <= '0;
            r_ovf  <= 1'b0;
        end else if (r_busy) begin
            r_num  <= {r_num[NUM_W-2:0], 1'b0};
            r_rem  <= n_rem;
            r_quot <= {r_quot[STEP_W-2:0], ge};
            // Any quotient bit above the low 32 saturates the step.
            r_ovf  <= r_ovf | r_quot[STEP_W-1];
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.ratio = r_ovf ? {STEP_W{1'b1}} : r_quot;

endmodule

[design/spectral_step_size_estimator.sv]
// Spectral (Barzilai-Borwein) step size estimator, top level.
// Depends on sse_pkg and instantiates the ratio divider sse_div.
//
// Usage: vector elements arrive one per input beat on the valid/ready input
// channel. Record elements store a position/gradient pair into history memory,
// compute elements read the stored pair at the same index and accumulate s.y
// and s.s, and a forget beat drops the history. The compute element marked
// last produces one output beat: the clamped step and the reason it was chosen.
// Non-last elements, record and forget beats are taken one per cycle while the
// input is not held closed; each compute element reads the history memory once.
// After a last compute element the input channel holds ready low until its
// result sits in the output register. A fallback step passes stages 1 and 2
// and the pending register; a spectral ratio also goes through the bit-serial
// divider (80 iterations, one quotient bit per cycle).
// While the receiver stalls, the output beat holds and the input takes new
// elements; a further result waits in a pending register until the output
// frees. Reset clears history valid, lengths, sums and handshakes and sets
// min_step to 1 and max_step to all ones. The history memory is not cleared.
// Configuration writes take effect at once and are meant for idle periods.
module spectral_step_size_estimator #(
    parameter int MAX_LEN = sse_pkg::DEF_MAX_LEN
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  sse_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output sse_pkg::t_out_item              o_out_data,
    input  logic                            i_cfg_we,
    input  logic [sse_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sse_pkg::STEP_W-1:0]      i_cfg_data
);
    import sse_pkg::*;

    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int MEM_W  = 2 * SAMPLE_WIDTH;
    localparam int DIFF_W = SAMPLE_WIDTH + 1;
    localparam int PROD_W = 2 * DIFF_W;

    function automatic logic [STEP_W-1:0] clamp_step(
        input logic [STEP_W-1:0] v,
        input logic [STEP_W-1:0] lo,
        input logic [STEP_W-1:0] hi
    );
        logic [STEP_W-1:0] t;
        t = (v < lo) ? lo : v;
        return (t > hi) ? hi : t;
    endfunction

    // Configuration and vector bookkeeping.
    logic [STEP_W-1:0] r_min_step;
    logic [STEP_W-1:0] r_max_step;
    logic [CNT_W-1:0]  r_count;
    logic              r_overrun;
    logic [CNT_W-1:0]  r_hist_len;
    logic              r_hist_valid;
    logic              r_busy;
    logic              n_busy;

    // History memory: position in the upper half, gradient in the lower half.
    logic [MEM_W-1:0]  r_mem [MAX_LEN];
    logic [MEM_W-1:0]  r_rd_data;

    // Stage 1: memory data returns.
    logic                    r_s1_valid;
    logic                    r_s1_use;
    logic                    r_s1_last;
    logic                    r_s1_clear;
    logic [SAMPLE_WIDTH-1:0] r_s1_x;
    logic [SAMPLE_WIDTH-1:0] r_s1_g;
    logic                    r_s1_no_hist;
    logic                    r_s1_mismatch;
    logic [STEP_W-1:0]       r_s1_init;

    // Stage 2: products registered, sums updated.
    logic              r_s2_valid;
    logic              r_s2_use;
    logic              r_s2_last;
    logic              r_s2_clear;
    logic              r_s2_neg;
    logic [PROD_W-1:0] r_s2_pss;
    logic [PROD_W-1:0] r_s2_psy;
    logic              r_s2_no_hist;
    logic              r_s2_mismatch;
    logic [STEP_W-1:0] r_s2_init;

    logic [SUM_W-1:0]  r_sum_sy;
    logic [SUM_W-1:0]  r_sum_ss;

    // Pending result and output register.
    logic              r_res_valid;
    logic [STEP_W-1:0] r_res_step;
    t_source           r_res_src;
    logic              r_out_valid;
    t_out_item         r_out_data;

    logic              in_fire;
    logic              is_comp;
    logic              is_rec;
    logic              is_forget;
    logic              have_slot;
    logic [CNT_W-1:0]  cnt_inc;
    logic              ovr_next;
    logic [ADDR_W-1:0] addr;

    logic [SAMPLE_WIDTH-1:0] mem_x;
    logic [SAMPLE_WIDTH-1:0] mem_g;
    logic [DIFF_W-1:0]       s_diff;
    logic [DIFF_W-1:0]       y_diff;
    logic [DIFF_W-1:0]       s_mag;
    logic [DIFF_W-1:0]       y_mag;

    logic [SUM_W:0]    add_ss;
    logic [SUM_W:0]    add_sy;
    logic [SUM_W-1:0]  acc_ss;
    logic [SUM_W-1:0]  acc_sy;
    t_source           src;
    logic              s2_final;
    logic              res_set;
    logic [STEP_W-1:0] res_raw;
    logic              res_move;

    t_div_req          div_req;
    t_div_rsp          div_rsp;

    // Input side.
    assign o_in_ready = !r_busy;
    assign in_fire    = i_in_valid && o_in_ready;
    assign is_comp    = i_in_data.action == ACT_COMPUTE;
    assign is_rec     = i_in_data.action == ACT_RECORD;
    assign is_forget  = i_in_data.action == ACT_FORGET;
    assign have_slot  = r_count < CNT_W'(MAX_LEN);
    assign cnt_inc    = have_slot ? r_count + CNT_W'(1) : r_count;
    assign ovr_next   = r_overrun || !have_slot;
    assign addr       = r_count[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_step <= STEP_W'(1);
            r_max_step <= {STEP_W{1'b1}};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIN_STEP: r_min_step <= i_cfg_data;
                CFG_MAX_STEP: r_max_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_overrun    <= 1'b0;
            r_hist_len   <= '0;
            r_hist_valid <= 1'b0;
        end else if (in_fire) begin
            if (is_forget) begin
                r_count      <= '0;
                r_overrun    <= 1'b0;
                r_hist_valid <= 1'b0;
            end else if (is_comp || is_rec) begin
                if (i_in_data.last_element) begin
                    r_count   <= '0;
                    r_overrun <= 1'b0;
                    if (is_rec) begin
                        r_hist_len   <= cnt_inc;
                        r_hist_valid <= !ovr_next;
                    end
                end else begin
                    r_count   <= cnt_inc;
                    r_overrun <= ovr_next;
                end
            end
        end
    end

    // Write and read never target the same beat, and a read in the next cycle
    // already sees the written entry, so no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (in_fire && is_rec && have_slot) begin
            r_mem[addr] <= {i_in_data.position_value, i_in_data.gradient_value};
        end
        if (in_fire && is_comp && have_slot) begin
            r_rd_data <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_fire && (is_comp || is_forget
                                      || (is_rec && i_in_data.last_element));
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_use      <= is_comp && have_slot;
        r_s1_last     <= is_comp && i_in_data.last_element;
        r_s1_clear    <= is_forget || (is_rec && i_in_data.last_element);
        r_s1_x        <= i_in_data.position_value;
        r_s1_g        <= i_in_data.gradient_value;
        r_s1_init     <= i_in_data.initial_step;
        r_s1_no_hist  <= !r_hist_valid;
        r_s1_mismatch <= ovr_next || (cnt_inc != r_hist_len);
    end

    // Stage 1: differences against history and their magnitudes.
    always_comb begin
        mem_x  = r_rd_data[MEM_W-1:SAMPLE_WIDTH];
        mem_g  = r_rd_data[SAMPLE_WIDTH-1:0];
        s_diff = {r_s1_x[SAMPLE_WIDTH-1], r_s1_x} - {mem_x[SAMPLE_WIDTH-1], mem_x};
        y_diff = {r_s1_g[SAMPLE_WIDTH-1], r_s1_g} - {mem_g[SAMPLE_WIDTH-1], mem_g};
        s_mag  = s_diff[DIFF_W-1] ? (~s_diff + DIFF_W'(1)) : s_diff;
        y_mag  = y_diff[DIFF_W-1] ? (~y_diff + DIFF_W'(1)) : y_diff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_use      <= r_s1_use;
        r_s2_last     <= r_s1_last;
        r_s2_clear    <= r_s1_clear;
        r_s2_neg      <= s_diff[DIFF_W-1] ^ y_diff[DIFF_W-1];
        r_s2_pss      <= PROD_W'(s_mag) * PROD_W'(s_mag);
        r_s2_psy      <= PROD_W'(s_mag) * PROD_W'(y_mag);
        r_s2_no_hist  <= r_s1_no_hist;
        r_s2_mismatch <= r_s1_mismatch;
        r_s2_init     <= r_s1_init;
    end

    // Stage 2: saturating accumulation and the decision on the last element.
    always_comb begin
        add_ss = {1'b0, r_sum_ss} + (SUM_W + 1)'(r_s2_pss);
        add_sy = r_s2_neg ? {r_sum_sy[SUM_W-1], r_sum_sy} - (SUM_W + 1)'(r_s2_psy)
                          : {r_sum_sy[SUM_W-1], r_sum_sy} + (SUM_W + 1)'(r_s2_psy);
        acc_ss = r_sum_ss;
        acc_sy = r_sum_sy;
        if (r_s2_use) begin
            acc_ss = add_ss[SUM_W] ? {SUM_W{1'b1}} : add_ss[SUM_W-1:0];
            if (add_sy[SUM_W] != add_sy[SUM_W-1]) begin
                // Signed overflow: saturate toward the sign of the true sum.
                acc_sy = add_sy[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                       : {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
                acc_sy = add_sy[SUM_W-1:0];
            end
        end

        if (r_s2_no_hist) begin
            src = SRC_NO_HISTORY;
        end else if (r_s2_mismatch) begin
            src = SRC_LEN_MISMATCH;
        end else if (acc_sy[SUM_W-1] || acc_sy == '0) begin
            src = SRC_CURVATURE;
        end else begin
            src = SRC_SPECTRAL;
        end

        s2_final      = r_s2_valid && r_s2_last;
        div_req.start = s2_final && (src == SRC_SPECTRAL);
        div_req.num   = acc_ss;
        div_req.den   = acc_sy[SUM_W-2:0];

        res_set  = (s2_final && (src != SRC_SPECTRAL)) || div_rsp.done;
        res_raw  = div_rsp.done ? div_rsp.ratio : r_s2_init;
        res_move = r_res_valid && (!r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_sy <= '0;
            r_sum_ss <= '0;
        end else if (r_s2_valid) begin
            if (r_s2_clear || r_s2_last) begin
                r_sum_sy <= '0;
                r_sum_ss <= '0;
            end else begin
                r_sum_sy <= acc_sy;
                r_sum_ss <= acc_ss;
            end
        end
    end

    sse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Result hand-off: pending register, then output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (res_set) begin
            r_res_valid <= 1'b1;
        end else if (res_move) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_set) begin
            r_res_step <= clamp_step(res_raw, r_min_step, r_max_step);
            r_res_src  <= div_rsp.done ? SRC_SPECTRAL : src;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_move) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_move) begin
            r_out_data.step_size   <= r_res_step;
            r_out_data.step_source <= r_res_src;
        end
    end

    // The input stays closed from a last compute element until its result moves out.
    always_comb begin
        n_busy = r_busy;
        if (in_fire && is_comp && i_in_data.last_element) begin
            n_busy = 1'b1;
        end else if (res_move) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[design/sse_check.sv]
// Port-level checker for the spectral step size estimator, with its bind.
// Depends on sse_pkg; sees only the top level's ports.
module sse_check (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input sse_pkg::t_in_item               i_in_data,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input sse_pkg::t_out_item              o_out_data
);
    import sse_pkg::*;

    // A stalled output beat holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed while stalled");

    // No result is shown, and the input is ready, in the cycle right after reset.
    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid && o_in_ready)
        else $error("handshake not cleared by reset");

    // A last compute element closes the input; only the closing is checked, not how long it lasts.
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.action == ACT_COMPUTE
            && i_in_data.last_element |=> !o_in_ready)
        else $error("input accepted right after a last compute element");

    // A result never appears in the cycle right after its last element.
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.action == ACT_COMPUTE
            && i_in_data.last_element && !o_out_valid |=> !o_out_valid)
        else $error("result shown too early");

endmodule

bind spectral_step_size_estimator sse_check u_sse_check (.*);

[dv/spectral_step_size_estimator_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for spectral_step_size_estimator: directed and random element beats,
// an in-bench step predictor and an in-order checker. Depends on sse_pkg and the RTL only.
module spectral_step_size_estimator_tb;
    import sse_pkg::*;

    localparam int MAX_LEN    = DEF_MAX_LEN;
    localparam int IDLE_PCT   = 29;
    localparam int SETTLE_CYC = 120;
    localparam int CYCLE_CAP  = 600000;
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam longint SY_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam longint SY_MIN = 64'h8000_0000_0000_0000;

    // How a compute element relates to the stored pair at its index.
    typedef enum int {MIX_FREE, MIX_DAMPED, MIX_STIFF, MIX_FLAT, MIX_STILL, MIX_ANTI} t_mix;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_in_item             in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = CFG_MIN_STEP;
    logic [STEP_W-1:0]    cfg_data = '0;

    t_in_item  beat_q[$];
    t_out_item step_q[$];
    bit        steady = 1'b0;
    int        errors = 0;
    int        cycles = 0;
    int        n_items = 0;
    int        src_seen[4] = '{0, 0, 0, 0};

    // Predictor state, updated on every accepted input beat.
    logic signed [SAMPLE_WIDTH-1:0] hist_x[MAX_LEN];
    logic signed [SAMPLE_WIDTH-1:0] hist_g[MAX_LEN];
    int                hist_len = 0;
    bit                hist_ok = 1'b0;
    int                elem_idx = 0;
    longint            acc_sy = 0;
    longint unsigned   acc_ss = 0;
    bit                overrun = 1'b0;
    logic [STEP_W-1:0] lo_step = 32'd1;
    logic [STEP_W-1:0] hi_step = '1;

    // Generator view of the element index and of what history holds, used to keep
    // compute reads on entries that were recorded and to pick vector lengths.
    bit                      gen_written[MAX_LEN];
    logic [SAMPLE_WIDTH-1:0] gen_x[MAX_LEN];
    logic [SAMPLE_WIDTH-1:0] gen_g[MAX_LEN];
    int                      gen_idx = 0;
    int                      gen_len = 0;

    spectral_step_size_estimator #(.MAX_LEN(MAX_LEN)) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor
    function automatic void clear_vector();
        elem_idx = 0;
        acc_sy   = 0;
        acc_ss   = 0;
        overrun  = 1'b0;
    endfunction

    function automatic logic [STEP_W-1:0] clamp_step(logic [STEP_W-1:0] v);
        logic [STEP_W-1:0] r;
        r = (v < lo_step) ? lo_step : v;
        return (r > hi_step) ? hi_step : r;
    endfunction

    // ss/sy in Q16.16, truncated; an integer part past 16 bits saturates.
    function automatic logic [STEP_W-1:0] bb_ratio(longint unsigned num, longint unsigned den);
        logic [79:0] q;
        q = {num, 16'h0} / {16'h0, den};
        return (q[79:32] != '0) ? {STEP_W{1'b1}} : q[31:0];
    endfunction

    task automatic predict_step(t_in_item it);
        bit                slot;
        bit                neg;
        int                idx;
        longint            s;
        longint            y;
        longint unsigned   ms;
        longint unsigned   my;
        logic signed [71:0] wide;
        logic [64:0]       ss_wide;
        t_out_item         res;
        if (it.action == ACT_FORGET) begin
            hist_ok = 1'b0;
            clear_vector();
        end else if (it.action == ACT_COMPUTE || it.action == ACT_RECORD) begin
            slot = elem_idx < MAX_LEN;
            idx  = elem_idx;
            if (slot) elem_idx++;
            else overrun = 1'b1;
            if (it.action == ACT_RECORD) begin
                if (slot) begin
                    hist_x[idx] = it.position_value;
                    hist_g[idx] = it.gradient_value;
                end
                if (it.last_element) begin
                    hist_len = elem_idx;
                    hist_ok  = !overrun;
                    clear_vector();
                end
            end else begin
                if (slot) begin
                    s  = $signed(it.position_value) - $signed(hist_x[idx]);
                    y  = $signed(it.gradient_value) - $signed(hist_g[idx]);
                    ms = (s < 0) ? -s : s;
                    my = (y < 0) ? -y : y;
                    neg = (s < 0) != (y < 0);
                    wide = acc_sy;
                    if (neg) wide = wide - $signed({8'd0, ms * my});
                    else wide = wide + $signed({8'd0, ms * my});
                    if (wide[71:63] != {9{wide[71]}}) acc_sy = wide[71] ? SY_MIN : SY_MAX;
                    else acc_sy = wide[63:0];
                    ss_wide = {1'b0, acc_ss} + {1'b0, ms * ms};
                    acc_ss = ss_wide[64] ? {64{1'b1}} : ss_wide[63:0];
                end
                if (it.last_element) begin
                    res.step_size = clamp_step(it.initial_step);
                    if (!hist_ok) begin
                        res.step_source = SRC_NO_HISTORY;
                    end else if (overrun || elem_idx != hist_len) begin
                        res.step_source = SRC_LEN_MISMATCH;
                    end else if (acc_sy <= 0) begin
                        res.step_source = SRC_CURVATURE;
                    end else begin
                        res.step_source = SRC_SPECTRAL;
                        res.step_size   = clamp_step(bb_ratio(acc_ss, acc_sy));
                    end
                    step_q.push_back(res);
                    clear_vector();
                end
            end
        end
    endtask

    // ---------------------------------------------------------------- driver and monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!(in_valid && !in_ready)) begin
            if (beat_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                in_data  <= beat_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        out_ready <= rst_n && (steady || $urandom_range(99) >= IDLE_PCT);
    end

    task automatic report(string what, logic [STEP_W-1:0] want, logic [STEP_W-1:0] got);
        errors++;
        $display("%0t: %s expected %h actual %h", $time, what, want, got);
    endtask

    // Output beats are checked before the input beat of the same edge is predicted.
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (step_q.size() == 0) begin
                report("unexpected step beat, step_size", '0, out_data.step_size);
            end else begin
                want = step_q.pop_front();
                if (out_data.step_size !== want.step_size)
                    report("step_size", want.step_size, out_data.step_size);
                if (out_data.step_source !== want.step_source)
                    report("step_source", want.step_source, out_data.step_source);
                src_seen[want.step_source]++;
            end
        end
        if (rst_n && in_valid && in_ready) predict_step(in_data);
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("Run timed out after %0d cycles.", cycles);
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    function automatic logic [SAMPLE_WIDTH-1:0] rand_sample();
        case ($urandom_range(7))
            0: return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
            1: return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
            2: return SAMPLE_WIDTH'($urandom_range(511)) - SAMPLE_WIDTH'(256);
            default: return SAMPLE_WIDTH'($urandom());
        endcase
    endfunction

    function automatic logic [STEP_W-1:0] rand_init();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return STEP_W'($urandom_range(32'h0008_0000));
            default: return $urandom();
        endcase
    endfunction

    task automatic push_item(logic [1:0] act, logic [SAMPLE_WIDTH-1:0] x,
                             logic [SAMPLE_WIDTH-1:0] g, logic [STEP_W-1:0] init, bit last);
        t_in_item it;
        // A compute at an index never recorded would read undefined memory; record there.
        if (act == ACT_COMPUTE && gen_idx < MAX_LEN && !gen_written[gen_idx]) act = ACT_RECORD;
        it = '{act, x, g, init, last};
        beat_q.push_back(it);
        if (act != ACT_UNUSED) n_items++;
        if (act == ACT_FORGET) begin
            gen_idx = 0;
        end else if (act != ACT_UNUSED) begin
            if (act == ACT_RECORD && gen_idx < MAX_LEN) begin
                gen_written[gen_idx] = 1'b1;
                gen_x[gen_idx] = x;
                gen_g[gen_idx] = g;
            end
            if (gen_idx < MAX_LEN) gen_idx++;
            if (last) begin
                if (act == ACT_RECORD) gen_len = gen_idx;
                gen_idx = 0;
            end
        end
    endtask

    task automatic push_compute(t_mix mix, bit last);
        logic [SAMPLE_WIDTH-1:0]        hx;
        logic [SAMPLE_WIDTH-1:0]        hg;
        logic [SAMPLE_WIDTH-1:0]        x;
        logic [SAMPLE_WIDTH-1:0]        g;
        logic signed [SAMPLE_WIDTH-1:0] d;
        logic signed [SAMPLE_WIDTH-1:0] e;
        hx = '0;
        hg = '0;
        if (gen_idx < MAX_LEN) begin
            hx = gen_x[gen_idx];
            hg = gen_g[gen_idx];
        end
        x = rand_sample();
        g = rand_sample();
        d = SAMPLE_WIDTH'($urandom_range(8191)) - SAMPLE_WIDTH'(4096);
        case (mix)
            MIX_DAMPED: begin
                e = d >>> $urandom_range(6);
                x = hx + d;
                g = hg + e;
            end
            MIX_STIFF: begin
                e = d <<< $urandom_range(6);
                x = hx + d;
                g = hg + e;
            end
            MIX_FLAT: begin
                // Large step with a unit gradient change pushes the ratio past 16 bits.
                d = rand_sample();
                x = hx + d;
                g = d[SAMPLE_WIDTH-1] ? hg - 1'b1 : hg + 1'b1;
            end
            MIX_STILL: begin
                x = hx;
                g = hg;
            end
            MIX_ANTI: begin
                x = hx + d;
                g = hg - d;
            end
            default: ;
        endcase
        push_item(ACT_COMPUTE, x, g, rand_init(), last);
    endtask

    task automatic record_vec(int len);
        for (int i = 0; i < len; i++)
            push_item(ACT_RECORD, rand_sample(), rand_sample(), rand_init(), i == len - 1);
    endtask

    task automatic compute_vec(int len, t_mix mix);
        for (int i = 0; i < len; i++) push_compute(mix, i == len - 1);
    endtask

    function automatic int vec_len();
        return ($urandom_range(19) == 0) ? $urandom_range(48, 13) : $urandom_range(8, 1);
    endfunction

    task automatic drain_results();
        while (beat_q.size() != 0 || in_valid || step_q.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    // A vector that ends without a result may still be in flight when the queue empties.
    task automatic settle();
        drain_results();
        repeat (SETTLE_CYC) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [STEP_W-1:0] v);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= v;
        if (idx == CFG_MIN_STEP) lo_step <= v;
        else hi_step <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(logic [STEP_W-1:0] lo, logic [STEP_W-1:0] hi, bit calm);
        settle();
        write_reg(CFG_MIN_STEP, lo);
        write_reg(CFG_MAX_STEP, hi);
        @(negedge clk);
        steady = calm;
    endtask

    task automatic run_phase(int count);
        int start;
        int pick;
        int len;
        int n;
        start = n_items;
        while (n_items - start < count) begin
            pick = $urandom_range(99);
            if (pick < 22) begin
                record_vec(vec_len());
            end else if (pick < 72) begin
                len = gen_len;
                case ($urandom_range(9))
                    0: len = len + 1;
                    1: len = len - 1;
                    2: len = vec_len();
                    default: ;
                endcase
                if (len < 1) len = 1;
                compute_vec(len, t_mix'($urandom_range(5)));
            end else if (pick < 78) begin
                push_item(ACT_FORGET, rand_sample(), rand_sample(), rand_init(),
                          $urandom_range(1));
            end else if (pick < 88) begin
                // Elements with no end; unless a forget follows, the next vector carries on counting from here.
                n = $urandom_range(4, 1);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(1)) push_compute(t_mix'($urandom_range(5)), 1'b0);
                    else push_item(ACT_RECORD, rand_sample(), rand_sample(), rand_init(), 1'b0);
                end
                if ($urandom_range(1))
                    push_item(ACT_FORGET, rand_sample(), rand_sample(), rand_init(), 1'b0);
            end else if (pick < 94) begin
                push_item(ACT_UNUSED, rand_sample(), rand_sample(), rand_init(),
                          $urandom_range(1));
            end else if (pick < 96) begin
                drain_results();
            end else begin
                push_item(2'($urandom_range(3)), rand_sample(), rand_sample(), rand_init(),
                          $urandom_range(1));
            end
        end
    endtask

    task automatic directed();
        // A stored vector at the extremes, then dropped: the fallback steps reach both bounds.
        push_item(ACT_RECORD, 24'h7F_FFFF, 24'h7F_FFFF, 32'h0, 1'b0);
        push_item(ACT_RECORD, 24'h80_0000, 24'h80_0000, 32'h0, 1'b0);
        push_item(ACT_RECORD, 24'h00_0001, 24'hFF_FFFF, 32'h0, 1'b1);
        push_item(ACT_FORGET, 24'h0, 24'h0, 32'h0, 1'b0);
        push_item(ACT_COMPUTE, 24'h12_3456, 24'h65_4321, 32'h0, 1'b1);
        push_item(ACT_COMPUTE, 24'h80_0000, 24'h7F_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_item(ACT_UNUSED, 24'hFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_item(ACT_RECORD, 24'h7F_FFFF, 24'h7F_FFFF, 32'h0, 1'b0);
        push_item(ACT_RECORD, 24'h80_0000, 24'h80_0000, 32'h0, 1'b0);
        push_item(ACT_RECORD, 24'h00_0001, 24'hFF_FFFF, 32'h0, 1'b1);
        // Full-scale differences with y equal to s: a step of exactly one.
        push_item(ACT_COMPUTE, 24'h80_0000, 24'h80_0000, 32'h0, 1'b0);
        push_item(ACT_COMPUTE, 24'h7F_FFFF, 24'h7F_FFFF, 32'h0, 1'b0);
        push_item(ACT_COMPUTE, 24'h00_0001, 24'hFF_FFFF, 32'h0003_0000, 1'b1);
        // Short vector.
        push_item(ACT_COMPUTE, 24'h00_0000, 24'h00_0000, 32'h0, 1'b0);
        push_item(ACT_COMPUTE, 24'h00_0000, 24'h00_0000, 32'h0002_8000, 1'b1);
        // Unit y against a large s: the quotient saturates.
        push_item(ACT_COMPUTE, 24'h00_0000, 24'h7F_FFFE, 32'h0, 1'b0);
        push_item(ACT_COMPUTE, 24'h80_0000, 24'h80_0000, 32'h0, 1'b0);
        push_item(ACT_COMPUTE, 24'h00_0001, 24'hFF_FFFF, 32'h0, 1'b1);
        // Negative curvature on the last element only.
        push_item(ACT_COMPUTE, 24'h7F_FFFF, 24'h7F_FFFF, 32'h0, 1'b0);
        push_item(ACT_COMPUTE, 24'h80_0000, 24'h80_0000, 32'h0, 1'b0);
        push_item(ACT_COMPUTE, 24'h7F_FFFF, 24'h80_0000, 32'h0001_0000, 1'b1);
        // Record elements and a compute share one count; history stays valid meanwhile.
        push_item(ACT_RECORD, 24'h12_3456, 24'h65_4321, 32'h0, 1'b0);
        push_item(ACT_RECORD, 24'h65_4321, 24'h12_3456, 32'h0, 1'b0);
        push_item(ACT_COMPUTE, 24'h00_0002, 24'h00_0000, 32'h0, 1'b1);
        // A record cut short by a forget leaves no history.
        push_item(ACT_RECORD, 24'h55_5555, 24'hAA_AAAA, 32'h0, 1'b0);
        push_item(ACT_FORGET, 24'h0, 24'h0, 32'h0, 1'b1);
        push_item(ACT_COMPUTE, 24'hAA_AAAA, 24'h55_5555, 32'h8000_0000, 1'b1);
    endtask

    initial begin
        logic [STEP_W-1:0] lo;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed();
        configure(32'h0, 32'hFFFF_FFFF, 1'b1);
        run_phase(100);
        configure(32'h0000_8000, 32'h0004_0000, 1'b0);
        run_phase(100);
        // Lower bound above upper bound: the upper bound wins.
        configure(32'h0003_0000, 32'h0002_0000, 1'b0);
        run_phase(100);
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        run_phase(80);
        configure(32'h0, 32'h0, 1'b0);
        run_phase(80);
        lo = $urandom() >> 14;
        configure(lo, lo + ($urandom() >> 12), 1'b0);
        run_phase(120);
        configure($urandom(), $urandom(), 1'b0);
        run_phase(120);

        // One vector writes every history entry as partial record elements and then
        // ends with a compute element one past the buffer; a short vector follows.
        configure(32'h0000_0100, 32'hFFFF_0000, 1'b0);
        record_vec(2);
        for (int i = 0; i < MAX_LEN; i++)
            push_item(ACT_RECORD, rand_sample(), rand_sample(), rand_init(), 1'b0);
        push_compute(MIX_FREE, 1'b1);
        compute_vec(2, MIX_DAMPED);

        settle();
        $display("Ran %0d element beats through eight clamp settings, full depth and overrun.",
                 n_items);
        $display("Steps checked: %0d spectral, %0d no history, %0d length, %0d curvature; %0d errors.",
                 src_seen[SRC_SPECTRAL], src_seen[SRC_NO_HISTORY], src_seen[SRC_LEN_MISMATCH],
                 src_seen[SRC_CURVATURE], errors);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[spectral_step_size_estimator.f]
design/sse_pkg.sv
design/sse_div.sv
design/spectral_step_size_estimator.sv
design/sse_check.sv
dv/spectral_step_size_estimator_tb.sv
